// ===== design/pbpi_pkg.sv =====
package pbpi_pkg;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_ACCEPTED = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // start/handshake group between the sequencer and the divider
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

// ===== design/pbpi_div.sv =====
module pbpi_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pbpi_pkg::div_req_t req_i,
  output pbpi_pkg::div_rsp_t rsp_o
);
  import pbpi_pkg::*;

  // restoring division, one quotient bit a cycle
  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [33:0] trial;
  logic [32:0] shifted;

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q[31:0], quo_q[63]};
    trial   = {1'b0, shifted} - {2'b00, den_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
      cnt_d  = 7'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_d = trial[32:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule

// ===== design/pbpi_mod.sv =====
module pbpi_mod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] rem_o
);
  // restoring remainder, one bit a cycle
  logic [31:0] num_q;
  logic [32:0] rem_q;
  logic [31:0] den_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] shifted;
  logic [33:0] trial;

  assign shifted = {rem_q[31:0], num_q[31]};
  assign trial   = {1'b0, shifted} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      num_q <= {num_q[30:0], 1'b0};
      rem_q <= trial[33] ? shifted : trial[32:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[31:0];
endmodule

// ===== design/periodic_breakpoint_profile_interp.sv =====
// Periodic breakpoint profile interpolator.
// Input channel (in_valid_i / in_stall_o) carries one request: mode, point_time,
// point_value and query_time. Output channel (out_valid_o / out_stall_i) gives
// exactly one result per request: setpoint (signed Q16.16) and status.
// Append stores a breakpoint in the table memory (times held non-decreasing),
// clear empties the table, query interpolates linearly between breakpoints,
// a query time past the last breakpoint wraps periodically.
// Clear, full, empty and unused mode go straight to the output register;
// append reads the last entry, then writes. A query takes the wrap (with the
// serial remainder unit when the time is past the end), a binary search over
// the memory's registered read port with a closing step, two further reads,
// a capture, a product step, a divider start and the serial divider when it
// interpolates; when the time lies before the first or at/after the last
// point it stops after the further reads. One request is worked on at a time;
// in_stall_o stays high until the result has been placed in the output
// register, and drops at that same clock edge.
// Reset clears the point count and total time; the table contents are not
// cleared, and entries not yet written may be read but their values go unused.
// While out_stall_i holds, the result stays in the output register and a new
// request may already be taken and worked up to its result.
module periodic_breakpoint_profile_interp #(
  parameter int MAX_POINTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] point_time_i,
  input  logic signed [31:0] point_value_i,
  input  logic [31:0] query_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] setpoint_o,
  output logic [1:0]  status_o
);
  import pbpi_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_POINTS);

  typedef enum logic [3:0] {
    S_IDLE, S_APPRD, S_APPWR, S_WRAP, S_SRCH, S_SRCHRD, S_RD0, S_RD1,
    S_MUL, S_PRD, S_DST, S_DIV, S_OUT
  } state_e;

  // table memories, one registered read port each
  logic [31:0] times_mem [MAX_POINTS];
  logic [31:0] vals_mem  [MAX_POINTS];
  logic [AW-1:0] rd_addr;
  logic [31:0] t_rd_q, v_rd_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_time, wr_val;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      times_mem[wr_addr] <= wr_time;
      vals_mem[wr_addr]  <= wr_val;
    end
    t_rd_q <= times_mem[rd_addr];
    v_rd_q <= vals_mem[rd_addr];
  end

  state_e        state_q;
  logic [CW-1:0] count_q;
  logic [31:0]   total_q;
  logic [31:0]   ptime_q, pval_q, t_q;
  logic [CW-1:0] lo_q, hi_q;
  logic [31:0]   t0_q, t1_q;
  logic signed [31:0] v0_q, v1_q;
  logic          neg_q;
  logic          sgn_q;
  logic [63:0]   prod_q;
  logic          res_valid_q;
  logic signed [31:0] res_sp_q;
  logic [1:0]    res_st_q;
  logic signed [31:0] out_sp_q;
  logic [1:0]    out_st_q;
  logic          mod_busy_q;

  logic [CW-1:0] mid;
  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  // remainder unit for the periodic wrap
  logic        mod_start, mod_done;
  logic [31:0] mod_rem;
  pbpi_mod u_mod (
    .clk_i, .rst_ni,
    .start_i(mod_start), .num_i(t_q - 32'd1), .den_i(total_q),
    .done_o(mod_done), .rem_o(mod_rem)
  );

  div_req_t div_req;
  div_rsp_t div_rsp;
  pbpi_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  logic signed [32:0] dv;
  logic [31:0]        mag;
  assign dv  = 33'(v1_q) - 33'(v0_q);
  assign mag = dv[32] ? 32'(-dv) : dv[31:0];

  logic out_free;
  assign out_free   = !res_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    unique case (state_q)
      S_APPRD: rd_addr = AW'(count_q - CW'(1));
      S_SRCH:  rd_addr = mid[AW-1:0];
      S_RD0:   rd_addr = (lo_q == '0) ? '0 : AW'(lo_q - CW'(1));
      S_RD1:   rd_addr = lo_q[AW-1:0];
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = (state_q == S_APPWR);
    wr_addr = count_q[AW-1:0];
    wr_time = (count_q != '0 && ptime_q < t_rd_q) ? t_rd_q : ptime_q;
    wr_val  = pval_q;
  end

  assign mod_start        = (state_q == S_WRAP) && (t_q > total_q) && !mod_busy_q;
  assign div_req.start    = (state_q == S_DST);
  assign div_req.dividend = prod_q;
  assign div_req.divisor  = t1_q - t0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      res_valid_q <= 1'b0;
      mod_busy_q  <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one is loaded this cycle
      if (res_valid_q && !out_stall_i && state_q != S_OUT) res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            ptime_q <= point_time_i;
            pval_q  <= point_value_i;
            t_q     <= query_time_i;
            res_sp_q <= '0;
            unique case (mode_e'(mode_i))
              MODE_APPEND: begin
                if (count_q >= MaxCnt) begin
                  res_st_q <= ST_FULL;
                  state_q  <= S_OUT;
                end else begin
                  state_q <= S_APPRD;
                end
              end
              MODE_QUERY: begin
                if (count_q == '0 || total_q == '0) begin
                  res_st_q <= ST_EMPTY;
                  state_q  <= S_OUT;
                end else begin
                  state_q <= S_WRAP;
                end
              end
              MODE_CLEAR: begin
                count_q  <= '0;
                total_q  <= '0;
                res_st_q <= ST_ACCEPTED;
                state_q  <= S_OUT;
              end
              default: begin
                res_st_q <= ST_EMPTY;
                state_q  <= S_OUT;
              end
            endcase
          end
        end
        S_APPRD: state_q <= S_APPWR;
        S_APPWR: begin
          total_q  <= wr_time;
          count_q  <= count_q + CW'(1);
          res_st_q <= ST_ACCEPTED;
          state_q  <= S_OUT;
        end
        S_WRAP: begin
          if (t_q <= total_q) begin
            lo_q    <= '0;
            hi_q    <= count_q;
            state_q <= S_SRCH;
          end else if (!mod_busy_q) begin
            mod_busy_q <= 1'b1;
          end else if (mod_done) begin
            mod_busy_q <= 1'b0;
            t_q        <= mod_rem + 32'd1;
            lo_q       <= '0;
            hi_q       <= count_q;
            state_q    <= S_SRCH;
          end
        end
        S_SRCH: begin
          // issue read of the midpoint, or finish the search
          if (lo_q >= hi_q) state_q <= S_RD0;
          else              state_q <= S_SRCHRD;
        end
        S_SRCHRD: begin
          if (t_rd_q <= t_q) lo_q <= mid + CW'(1);
          else               hi_q <= mid;
          state_q <= S_SRCH;
        end
        S_RD0: begin
          if (lo_q == '0) begin
            lo_q <= CW'(1);     // before the first point: read entry zero
            state_q <= S_RD1;
            neg_q <= 1'b1;
          end else begin
            neg_q   <= 1'b0;
            state_q <= S_RD1;
          end
        end
        S_RD1: begin
          t0_q <= t_rd_q;
          v0_q <= v_rd_q;
          if (neg_q || lo_q >= count_q) begin
            // before first or at/after last: the value just read
            res_sp_q <= v_rd_q;
            res_st_q <= ST_DONE;
            state_q  <= S_OUT;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          // v1 and t1 arrive in the read register this cycle
          state_q <= S_PRD;
        end
        S_PRD: state_q <= S_DST;
        S_DST: state_q <= S_DIV;
        S_DIV: begin
          if (div_rsp.done) begin
            if (t1_q == t0_q)
              res_sp_q <= v0_q;
            else if (sgn_q)
              res_sp_q <= v0_q - div_rsp.quotient[31:0];
            else
              res_sp_q <= v0_q + div_rsp.quotient[31:0];
            res_st_q <= ST_DONE;
            state_q  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            res_valid_q <= 1'b1;
            out_sp_q    <= res_sp_q;
            out_st_q    <= res_st_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // capture v1/t1 from the read register, then form the product and sign
  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      t1_q <= t_rd_q;
      v1_q <= v_rd_q;
    end
    if (state_q == S_PRD) begin
      prod_q <= 64'(mag) * 64'(t_q - t0_q);
      sgn_q  <= dv[32];
    end
  end

  assign setpoint_o  = out_sp_q;
  assign status_o    = out_st_q;
  assign out_valid_o = res_valid_q;
endmodule

// ===== verif/tb_periodic_breakpoint_profile_interp.sv =====
`timescale 1ns / 1ps

module tb_periodic_breakpoint_profile_interp;
  import pbpi_pkg::*;

  localparam int MAX_POINTS = 256;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1600;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] point_time;
    logic [31:0] point_value;
    logic [31:0] query_time;
  } request_t;

  typedef struct packed {
    logic [31:0] setpoint;
    status_e     status;
  } setpoint_rsp_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         mode_i;
  logic [31:0]        point_time_i;
  logic signed [31:0] point_value_i;
  logic [31:0]        query_time_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] setpoint_o;
  logic [1:0]         status_o;

  periodic_breakpoint_profile_interp #(.MAX_POINTS(MAX_POINTS)) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .point_time_i (point_time_i),
    .point_value_i(point_value_i),
    .query_time_i (query_time_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .setpoint_o   (setpoint_o),
    .status_o     (status_o)
  );

  // Local copy of the profile table, advanced as requests are accepted
  logic [31:0] prof_times [MAX_POINTS];
  logic [31:0] prof_values[MAX_POINTS];
  int unsigned prof_count;
  logic [31:0] prof_total;

  request_t      pending_requests[$];
  setpoint_rsp_t expected_setpoints[$];
  int  mismatches;
  int  watchdog;
  bit  stimulus_done;
  bit  hold_sender;
  bit  calm_sender;
  bit  calm_receiver;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Interpolate at time t over the local table; assumes count > 0, total > 0
  function automatic logic [31:0] interp_setpoint(logic [31:0] t);
    int unsigned lo, hi, mid, idx;
    logic signed [63:0] v0, v1, dv, q;
    logic [63:0] mag, prod;
    logic [31:0] num, den;
    lo = 0;
    hi = prof_count;
    if (t > prof_total) t = ((t - 32'd1) % prof_total) + 32'd1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (prof_times[mid] <= t) lo = mid + 1;
      else hi = mid;
    end
    if (lo == 0) return prof_values[0];
    idx = lo - 1;
    if (idx >= prof_count - 1) return prof_values[prof_count-1];
    v0 = $signed(prof_values[idx]);
    v1 = $signed(prof_values[idx+1]);
    num = t - prof_times[idx];
    den = prof_times[idx+1] - prof_times[idx];
    if (den == 0) return v0[31:0];
    dv = v1 - v0;
    mag = (dv < 0) ? 64'(-dv) : 64'(dv);
    prod = mag * {32'd0, num};
    q = $signed(prod / {32'd0, den});
    return (dv < 0) ? 32'(v0 - q) : 32'(v0 + q);
  endfunction

  // Advance the table and work out the one result a request causes
  function automatic setpoint_rsp_t apply_request(request_t r);
    setpoint_rsp_t rsp;
    logic [31:0] pt;
    rsp.setpoint = '0;
    rsp.status = ST_EMPTY;
    case (r.mode)
      MODE_APPEND: begin
        if (prof_count >= MAX_POINTS) begin
          rsp.status = ST_FULL;
        end else begin
          pt = r.point_time;
          if (prof_count > 0 && pt < prof_times[prof_count-1]) pt = prof_times[prof_count-1];
          prof_times[prof_count] = pt;
          prof_values[prof_count] = r.point_value;
          prof_count++;
          prof_total = pt;
          rsp.status = ST_ACCEPTED;
        end
      end
      MODE_QUERY: begin
        if (prof_count != 0 && prof_total != 0) begin
          rsp.setpoint = interp_setpoint(r.query_time);
          rsp.status = ST_DONE;
        end
      end
      MODE_CLEAR: begin
        prof_count = 0;
        prof_total = '0;
        rsp.status = ST_ACCEPTED;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic request_t make_request(mode_e m, logic [31:0] pt, logic [31:0] pv,
                                            logic [31:0] qt);
    request_t r;
    r.mode = m;
    r.point_time = pt;
    r.point_value = pv;
    r.query_time = qt;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'd0);
      default: return $urandom;
    endcase
  endfunction

  // Driver: take the next request from the queue, hold it while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      mode_i        <= MODE_NONE;
      point_time_i  <= '0;
      point_value_i <= '0;
      query_time_i  <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) expected_setpoints.push_back(apply_request(
          make_request(mode_e'(mode_i), point_time_i, point_value_i, query_time_i)));
      if (pending_requests.size() > 0 && !hold_sender &&
          (calm_sender || $urandom_range(0, 99) >= 14)) begin
        request_t r;
        r = pending_requests.pop_front();
        in_valid_i    <= 1'b1;
        mode_i        <= r.mode;
        point_time_i  <= r.point_time;
        point_value_i <= r.point_value;
        query_time_i  <= r.query_time;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_setpoints.size() == 0) begin
          $error("result with nothing expected: setpoint %0d status %0d",
                 setpoint_o, status_o);
          mismatches++;
        end else begin
          setpoint_rsp_t e;
          e = expected_setpoints.pop_front();
          if (setpoint_o !== e.setpoint) begin
            $error("setpoint: expected %0d actual %0d", $signed(e.setpoint), setpoint_o);
            mismatches++;
          end
          if (status_o !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, status_o);
            mismatches++;
          end
        end
      end
      out_stall_i <= !calm_receiver && ($urandom_range(0, 99) < 14);
    end
  end

  // Watchdog: count cycles with no request or result moving
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      watchdog <= 0;
    end else begin
      watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Clear and fill a table with n points, mostly rising and close together, then query it
  task automatic queue_profile(int n, int queries);
    logic [31:0] t;
    t = $urandom_range(0, 40);
    pending_requests.push_back(make_request(MODE_CLEAR, rand_word(), rand_word(), rand_word()));
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) t = t - $urandom_range(0, 30); // decreasing: saturate
      else t = t + $urandom_range(0, 200);
      pending_requests.push_back(make_request(MODE_APPEND, t, rand_word(), rand_word()));
    end
    for (int k = 0; k < queries; k++)
      pending_requests.push_back(make_request(MODE_QUERY, rand_word(), rand_word(),
          ($urandom_range(0, 3) == 0) ? rand_word() : $urandom_range(0, 3 * t + 2)));
  endtask

  initial begin
    int queued;
    mismatches = 0;
    watchdog = 0;
    stimulus_done = 0;
    hold_sender = 0;
    calm_sender = 0;
    calm_receiver = 0;
    prof_count = 0;
    prof_total = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, unused mode, zero total, extremes, wrap, flat span
    pending_requests.push_back(make_request(MODE_QUERY, 0, 0, 32'd5));
    pending_requests.push_back(make_request(MODE_NONE, 32'hFFFF_FFFF, 32'h8000_0000, 0));
    pending_requests.push_back(make_request(MODE_APPEND, 0, 32'h7FFF_FFFF, 0));
    pending_requests.push_back(make_request(MODE_QUERY, 0, 0, 32'hFFFF_FFFF));
    pending_requests.push_back(make_request(MODE_APPEND, 100, 32'h8000_0000, 0));
    pending_requests.push_back(make_request(MODE_APPEND, 50, 32'h0001_0000, 0));
    pending_requests.push_back(make_request(MODE_APPEND, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0));
    pending_requests.push_back(make_request(MODE_QUERY, 0, 0, 0));
    pending_requests.push_back(make_request(MODE_QUERY, 0, 0, 50));
    pending_requests.push_back(make_request(MODE_QUERY, 0, 0, 1000));
    pending_requests.push_back(make_request(MODE_QUERY, 0, 0, 32'hFFFF_FFFF));
    pending_requests.push_back(make_request(MODE_QUERY, 0, 0, 32'h8000_0000));
    pending_requests.push_back(make_request(MODE_CLEAR, 0, 0, 0));
    pending_requests.push_back(make_request(MODE_APPEND, 10, 32'hFFFF_0000, 0));
    pending_requests.push_back(make_request(MODE_APPEND, 20, 32'h0000_0100, 0));
    pending_requests.push_back(make_request(MODE_QUERY, 0, 0, 5));
    pending_requests.push_back(make_request(MODE_QUERY, 0, 0, 15));
    pending_requests.push_back(make_request(MODE_QUERY, 0, 0, 37));
    pending_requests.push_back(make_request(MODE_QUERY, 0, 0, 32'hFFFF_FFFF));

    // Fill to capacity, then overflow and query the full table
    queue_profile(MAX_POINTS, 4);
    pending_requests.push_back(make_request(MODE_APPEND, 32'hFFFF_FFFF, 32'h1234_5678, 0));
    pending_requests.push_back(make_request(MODE_QUERY, 0, 0, 32'hFFFF_FFFF));
    queued = 19 + MAX_POINTS + 7;

    // Pause the sender until everything outstanding has returned
    wait (pending_requests.size() == 0);
    hold_sender = 1;
    wait (expected_setpoints.size() == 0 && !in_valid_i);
    hold_sender = 0;

    // Random profiles, mostly small, with noise requests mixed in
    while (queued < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        pending_requests.push_back(make_request(mode_e'($urandom_range(0, 3)), rand_word(),
                                                rand_word(), rand_word()));
        queued++;
      end else begin
        int n;
        int nq;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(2, MAX_POINTS) : $urandom_range(1, 8);
        nq = $urandom_range(2, 12);
        queue_profile(n, nq);
        queued += n + nq + 1;
      end
      if (queued > RANDOM_ITEMS / 2 && queued < RANDOM_ITEMS / 2 + 300) begin
        calm_sender = 1;
        calm_receiver = 1;
      end else begin
        calm_sender = 0;
        calm_receiver = 0;
      end
      wait (pending_requests.size() < 20);
    end

    wait (pending_requests.size() == 0 && !in_valid_i);
    wait (expected_setpoints.size() == 0);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_setpoints.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/pbpi_pkg.sv
design/pbpi_div.sv
design/pbpi_mod.sv
design/periodic_breakpoint_profile_interp.sv
verif/tb_periodic_breakpoint_profile_interp.sv
